@@ src/spc_pkg.sv @@
// Shared constants, types and controller codes for the sieve prime counter.
package spc_pkg;

  // Bitmap size and derived widths
  localparam int MAX_N     = 65536;
  localparam int ADDR_W    = $clog2(MAX_N);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int P_W       = (ADDR_W + 1) / 2 + 1;
  localparam int SQ_W      = 2 * P_W;
  localparam int LIMIT_W   = 20;
  localparam int COUNT_W   = 13;
  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TEST,
    ST_READ,
    ST_CHECK,
    ST_MARK,
    ST_COUNT,
    ST_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture limit, reset address counter
    logic wr_zero;   // clear bitmap entry at address counter, step counter
    logic p_init;    // candidate p <= 2
    logic p_inc;     // next candidate
    logic rd_p;      // read bitmap entry p
    logic m_init;    // first multiple m <= p*p
    logic mark;      // mark entry m composite, m <= m + p
    logic cnt_init;  // address counter <= 2, count <= 0
    logic cnt_rd;    // read entry at address counter, step counter
    logic out_load;  // move count into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic addr_le_n;
    logic psq_le_n;
    logic m_le_n;
    logic p_marked;
    logic out_free;
  } stat_t;

endpackage

@@ src/spc_ram.sv @@
// Generic single-port RAM with registered read data.
module spc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read on one port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/spc_ctrl.sv @@
// Controller state machine: clear pass, sieve loop, count pass, result hand-off.
module spc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  spc_pkg::stat_t stat,
  output spc_pkg::cmd_t  cmd
);
  import spc_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CLEAR;
      ST_CLEAR: if (!stat.addr_le_n) state_next = ST_TEST;
      ST_TEST:  state_next = stat.psq_le_n ? ST_READ : ST_COUNT;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = stat.p_marked ? ST_TEST : ST_MARK;
      ST_MARK:  if (!stat.m_le_n) state_next = ST_TEST;
      ST_COUNT: if (!stat.addr_le_n) state_next = ST_FIN;
      ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // no transfer is taken while reset is held
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_CLEAR: begin
        cmd.wr_zero = stat.addr_le_n;
        cmd.p_init  = !stat.addr_le_n;
      end
      ST_TEST: begin
        cmd.cnt_init = !stat.psq_le_n;
      end
      ST_READ: begin
        cmd.rd_p = 1'b1;
      end
      ST_CHECK: begin
        cmd.p_inc  = stat.p_marked;
        cmd.m_init = !stat.p_marked;
      end
      ST_MARK: begin
        cmd.mark  = stat.m_le_n;
        cmd.p_inc = !stat.m_le_n;
      end
      ST_COUNT: begin
        cmd.cnt_rd = stat.addr_le_n;
      end
      ST_FIN: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/spc_dpath.sv @@
// Datapath: limit clamp, counters, bitmap memory, prime count and output register.
module spc_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  spc_pkg::cmd_t                      cmd,
  output spc_pkg::stat_t                     stat,
  input  logic [spc_pkg::LIMIT_W-1:0]        limit,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [spc_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_clamped
);
  import spc_pkg::*;

  localparam logic [LIMIT_W-1:0] N_TOP = LIMIT_W'(MAX_N - 1);

  logic [ADDR_W-1:0]  n;
  logic               clamped;
  logic [CNT_W-1:0]   addr;
  logic [P_W-1:0]     p;
  logic [CNT_W-1:0]   m;
  logic [COUNT_W-1:0] count;
  logic               rd_pend;
  logic [SQ_W-1:0]    psq;
  logic [CNT_W-1:0]   n_ext;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic               ram_rdata;

  assign n_ext = {1'b0, n};
  assign psq   = p * p;

  // Limit capture with clamp
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (limit > N_TOP) begin
        n       <= ADDR_W'(MAX_N - 1);
        clamped <= 1'b1;
      end else begin
        n       <= limit[ADDR_W-1:0];
        clamped <= 1'b0;
      end
    end
  end

  // Address counter shared by clear and count passes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr <= '0;
    end else if (cmd.cnt_init) begin
      addr <= CNT_W'(2);
    end else if (cmd.wr_zero || cmd.cnt_rd) begin
      addr <= addr + 1'b1;
    end
  end

  // Candidate and multiple registers
  always_ff @(posedge clk) begin
    if (cmd.p_init) begin
      p <= P_W'(2);
    end else if (cmd.p_inc) begin
      p <= p + 1'b1;
    end
    if (cmd.m_init) begin
      m <= psq[CNT_W-1:0];
    end else if (cmd.mark) begin
      m <= m + {{(CNT_W-P_W){1'b0}}, p};
    end
  end

  // Bitmap port selection
  always_comb begin
    ram_we = cmd.wr_zero | cmd.mark;
    if (cmd.mark) begin
      ram_addr = m[ADDR_W-1:0];
    end else if (cmd.rd_p) begin
      ram_addr = {{(ADDR_W-P_W){1'b0}}, p};
    end else begin
      ram_addr = addr[ADDR_W-1:0];
    end
  end

  spc_ram #(
    .WIDTH (1),
    .DEPTH (MAX_N)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd.mark),
    .rdata (ram_rdata)
  );

  // Count unmarked entries one read behind the address counter
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.cnt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_init) begin
      count <= '0;
    end else if (rd_pend && !ram_rdata && count != COUNT_W'(COUNT_MAX)) begin
      count <= count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_count   <= count;
      out_clamped <= clamped;
    end
  end

  // Status
  assign stat.addr_le_n = addr <= n_ext;
  assign stat.psq_le_n  = psq <= {{(SQ_W-ADDR_W){1'b0}}, n};
  assign stat.m_le_n    = m <= n_ext;
  assign stat.p_marked  = ram_rdata;
  assign stat.out_free  = !out_valid || out_ready;

endmodule

@@ src/sieve_prime_counter.sv @@
// Top level of the sieve prime counter: stream ports, controller and datapath.
//
// Each input transfer carries a limit n; the block answers with the number of
// primes in 2..n, n clamped to 65535 (the clamped flag is then set). Work walks
// a 65536 x 1 bitmap RAM with one access per cycle: a clearing pass over entries
// 0..n, the sieve (test, read and check states for each candidate p with
// p*p <= n, and for each prime p a mark of every multiple from p*p up to n),
// and a counting pass over 2..n. One request is in work at a time; a new
// request is taken as soon as the previous result sits in the output register,
// even if that result has not yet been taken.
module sieve_prime_counter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [spc_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [19:0] limit, [23:20] zero
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [spc_pkg::OUT_DATA_W-1:0]   m_axis_tdata    // [12:0] prime_count, [13] clamped,
                                                           // [15:14] zero
);
  import spc_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [COUNT_W-1:0] out_count;
  logic               out_clamped;

  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .limit       (s_axis_tdata[LIMIT_W-1:0]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_count   (out_count),
    .out_clamped (out_clamped)
  );

  // Result packing
  assign m_axis_tdata = {{(OUT_DATA_W-COUNT_W-1){1'b0}}, out_clamped, out_count};

endmodule
